### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked on every rising clock edge outside reset
`define TSDA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// checked on every rising clock edge, reset included
`define TSDA_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define TSDA_ASSERT(lbl, clk, rstn, prop)
`define TSDA_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

### rtl/tsda_pkg.sv
package tsda_pkg;

    localparam int STAMP_W    = 32;
    localparam int ID_W       = 4;
    localparam int SEC_W      = STAMP_W - ID_W;
    localparam int BCD_W      = 4;
    localparam int SEC_DIGITS = 9;
    localparam int TEXT_LEN   = 12;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = $clog2(SEC_W);
    localparam int POS_W      = $clog2(TEXT_LEN);

    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [CHAR_W-1:0]  t_char;

    localparam t_char ZERO_CHAR   = 8'd48;
    localparam t_char PERIOD_CHAR = 8'd46;

    localparam logic [ID_W-1:0]  ID_TEN    = 4'd10;
    localparam logic [BCD_W-1:0] BCD_LIMIT = 4'd5;
    localparam logic [BCD_W-1:0] BCD_ADJ   = 4'd3;

endpackage

### rtl/tsda_in_if.sv
interface tsda_in_if;
    import tsda_pkg::*;

    logic   valid;
    logic   ready;
    t_stamp stamp;

    modport source (output valid, output stamp, input ready);
    modport sink   (input valid, input stamp, output ready);
endinterface

### rtl/tsda_out_if.sv
interface tsda_out_if;
    import tsda_pkg::*;

    logic  valid;
    logic  ready;
    t_char text_char;
    logic  last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

### rtl/timestamp_to_decimal_ascii_unit.sv
// Timestamp to decimal ASCII text.
// i_in carries one 32-bit stamp per word: seconds in bits 31..4, sequence
// id in bits 3..0. o_out returns twelve words per stamp, one ASCII
// character each: nine zero-padded decimal digits of the seconds, most
// significant first, a period, then two digits of the id. last_char marks
// the twelfth character.
// The seconds are converted by a double dabble shift register, one binary
// bit per cycle; the seconds digits then leave one per cycle, while the
// receiver is ready, from the top of the same digit shift register.
// A stamp is first accepted, then its seconds are converted, then its
// twelve characters are sent; the block is ready for the next stamp in
// the cycle after the last character is taken.
// i_in.ready is high only while no stamp is in work.
// A stall on o_out holds the current character and everything behind it.
// Reset (synchronous, active low) drops any stamp in work, clears the
// output valid and leaves the block ready for a new stamp.
`include "assert_macros.svh"

module timestamp_to_decimal_ascii_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsda_in_if.sink     i_in,
    tsda_out_if.source  o_out
);
    import tsda_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam int BCD_TOT = SEC_DIGITS * BCD_W;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SEC_W-1:0]   r_sec, n_sec;
    logic [BCD_TOT-1:0] r_bcd, n_bcd;
    logic [ID_W-1:0]    r_id, n_id;

    logic [BCD_TOT-1:0] adj_bcd;
    logic               in_acc;
    logic               out_acc;
    logic               id_ge_ten;
    logic               conv_last;
    t_char              cur_char;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = o_out.valid && o_out.ready;
    assign id_ge_ten = (r_id >= ID_TEN);
    assign conv_last = (r_state == S_CONV) && (r_cnt == CNT_W'(SEC_W - 1));

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < SEC_DIGITS; d++) begin
            if (r_bcd[d*BCD_W +: BCD_W] >= BCD_LIMIT) begin
                adj_bcd[d*BCD_W +: BCD_W] = r_bcd[d*BCD_W +: BCD_W] + BCD_ADJ;
            end else begin
                adj_bcd[d*BCD_W +: BCD_W] = r_bcd[d*BCD_W +: BCD_W];
            end
        end
    end

    always_comb begin
        if (r_pos < POS_W'(SEC_DIGITS)) begin
            cur_char = ZERO_CHAR + CHAR_W'(r_bcd[BCD_TOT-1 -: BCD_W]);
        end else if (r_pos == POS_W'(SEC_DIGITS)) begin
            cur_char = PERIOD_CHAR;
        end else if (r_pos == POS_W'(SEC_DIGITS + 1)) begin
            cur_char = id_ge_ten ? ZERO_CHAR + CHAR_W'(1) : ZERO_CHAR;
        end else begin
            cur_char = id_ge_ten ? ZERO_CHAR + CHAR_W'(r_id - ID_TEN)
                                 : ZERO_CHAR + CHAR_W'(r_id);
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_EMIT);
    assign o_out.text_char = cur_char;
    assign o_out.last_char = (r_pos == POS_W'(TEXT_LEN - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_sec   = r_sec;
        n_bcd   = r_bcd;
        n_id    = r_id;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sec   = i_in.stamp[STAMP_W-1:ID_W];
                    n_id    = i_in.stamp[ID_W-1:0];
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_pos   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {adj_bcd[BCD_TOT-2:0], r_sec[SEC_W-1]};
                n_sec = {r_sec[SEC_W-2:0], 1'b0};
                n_cnt = r_cnt + CNT_W'(1);
                if (conv_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    // next digit moves to the top
                    n_bcd = {r_bcd[BCD_TOT-BCD_W-1:0], {BCD_W{1'b0}}};
                    n_pos = r_pos + POS_W'(1);
                    if (o_out.last_char) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec <= n_sec;
        r_bcd <= n_bcd;
        r_id  <= n_id;
    end

    `TSDA_ASSERT(a_no_accept_while_emit, i_clk, i_rst_n, o_out.valid |-> !i_in.ready)
    `TSDA_ASSERT(a_accept_starts_conv, i_clk, i_rst_n, in_acc |=> (r_state == S_CONV))
    `TSDA_ASSERT(a_conv_done_emits, i_clk, i_rst_n, conv_last |=> (o_out.valid && r_pos == '0))
    `TSDA_ASSERT(a_last_frees_input, i_clk, i_rst_n, (out_acc && o_out.last_char) |=> i_in.ready)
    `TSDA_ASSERT_NORST(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out.valid)

endmodule

### test/timestamp_to_decimal_ascii_unit_tb.sv
module timestamp_to_decimal_ascii_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsda_pkg::*;

    typedef struct packed {
        t_char text_char;
        logic  last_char;
    } t_text_word;

    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_WAIT = 60;

    // corner stamps: all zero, all one, id extremes, digit roll-overs, alternating bits
    localparam t_stamp EDGE_STAMPS [18] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000F, 32'h0000_0009,
        32'h0000_000A, 32'hFFFF_FFF0, 32'h0000_0010, 32'h5F5E_0FF3,
        32'h5F5E_1005, 32'hBEBC_1FFB, 32'hBEBC_200C, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h75BC_D15E, 32'h0000_00AD,
        32'h0000_009B, 32'h00F4_23FC
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tsda_in_if  in_ch ();
    tsda_out_if out_ch ();

    timestamp_to_decimal_ascii_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_stamp     pending_stamps [$];
    t_text_word expected_text [$];
    t_text_word char_due;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int errors        = 0;
    int stamps_taken  = 0;
    int chars_checked = 0;
    int cycle_cnt     = 0;

    always #5 i_clk = ~i_clk;

    // twelve characters of one stamp: 9 seconds digits, period, 2 id digits
    function automatic void predict_text(t_stamp stamp);
        logic [SEC_W-1:0] secs;
        logic [ID_W-1:0]  id;
        logic [BCD_W-1:0] digits [SEC_DIGITS];
        t_text_word       w;
        secs = stamp[STAMP_W-1:ID_W];
        id   = stamp[ID_W-1:0];
        for (int i = SEC_DIGITS - 1; i >= 0; i--) begin
            digits[i] = BCD_W'(secs % 10);
            secs      = SEC_W'(secs / 10);
        end
        w.last_char = 1'b0;
        for (int i = 0; i < SEC_DIGITS; i++) begin
            w.text_char = ZERO_CHAR + t_char'(digits[i]);
            expected_text.push_back(w);
        end
        w.text_char = PERIOD_CHAR;
        expected_text.push_back(w);
        w.text_char = ZERO_CHAR + ((id >= ID_TEN) ? t_char'(1) : t_char'(0));
        expected_text.push_back(w);
        w.text_char = ZERO_CHAR + t_char'((id >= ID_TEN) ? id - ID_TEN : id);
        w.last_char = 1'b1;
        expected_text.push_back(w);
    endfunction

    function automatic t_stamp random_stamp();
        case ($urandom_range(0, 9))
            0, 1:    return {SEC_W'($urandom_range(0, 999)), ID_W'($urandom)};
            2:       return {SEC_W'(28'hFFF_FFFF - $urandom_range(0, 50)), ID_W'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_text_drained();
        while (pending_stamps.size() > 0 || in_ch.valid || expected_text.size() > 0)
            @(negedge i_clk);
    endtask

    // stamp driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.stamp <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                predict_text(in_ch.stamp);
                stamps_taken++;
            end
            if (pending_stamps.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_ch.stamp <= pending_stamps.pop_front();
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // character monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_text.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word: char %h last %b", $time,
                             out_ch.text_char, out_ch.last_char);
                end else begin
                    char_due = expected_text.pop_front();
                    chars_checked++;
                    if (out_ch.text_char !== char_due.text_char) begin
                        errors++;
                        $display("%0t: text_char expected %h got %h", $time,
                                 char_due.text_char, out_ch.text_char);
                    end
                    if (out_ch.last_char !== char_due.last_char) begin
                        errors++;
                        $display("%0t: last_char expected %b got %b", $time,
                                 char_due.last_char, out_ch.last_char);
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, expected_text.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.stamp  = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 26;
        recv_idle_pct = 45;
        foreach (EDGE_STAMPS[i]) pending_stamps.push_back(EDGE_STAMPS[i]);
        repeat (70) pending_stamps.push_back(random_stamp());
        // wait until every stamp is sent and all text is out
        wait_text_drained();

        send_idle_pct = 45;
        recv_idle_pct = 26;
        hold_req++;
        repeat (90) pending_stamps.push_back(random_stamp());
        wait_text_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (90) pending_stamps.push_back(random_stamp());
        wait_text_drained();

        repeat (SETTLE_WAIT) @(negedge i_clk);
        $display("covered %0d stamps (corner seconds and ids, random), %0d words checked",
                 stamps_taken, chars_checked);
        $display("idle mixes 26/45, 45/26 and none, plus one long receiver hold");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tsda_pkg.sv
rtl/tsda_in_if.sv
rtl/tsda_out_if.sv
rtl/timestamp_to_decimal_ascii_unit.sv
test/timestamp_to_decimal_ascii_unit_tb.sv
